// ===== hdl/vzs_pkg.sv =====
// Shared types, codes and constants of the valve zone step sequencer.
// Used by the channel interfaces, the core, the step table and the checker.
// Depends on nothing.
package vzs_pkg;

    // Sizes of the step table and of the zone set.
    localparam int SLOT_COUNT = 8;
    localparam int VALVE_ZONES = 4;
    localparam logic [2:0] ZONES = 3'd4;
    localparam logic [3:0] MAX_STEPS = 4'd8;

    // Limits and scale factors of a step.
    localparam logic [10:0] MINUTES_LIMIT = 11'd1440;
    localparam logic [16:0] SEC_PER_MIN = 17'd60;

    // Configuration register indexes and reset values.
    localparam logic CFG_DEFAULT_WAKE = 1'b0;
    localparam logic CFG_POLL = 1'b1;
    localparam logic [15:0] DEFAULT_WAKE_RESET = 16'd300;
    localparam logic [15:0] POLL_RESET = 16'd60;

    // Action codes of an input transaction.
    localparam logic [2:0] ACT_TICK = 3'd0;
    localparam logic [2:0] ACT_LOAD = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_STOP = 3'd3;
    localparam logic [2:0] ACT_MANUAL = 3'd4;

    // Status codes of a result transaction.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WATERING = 3'd1;
    localparam logic [2:0] ST_FINISHED = 3'd2;
    localparam logic [2:0] ST_DISABLED = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;

    // Last applied valve state of a zone.
    localparam logic [1:0] APPLIED_CLOSED = 2'd0;
    localparam logic [1:0] APPLIED_OPEN = 2'd1;
    localparam logic [1:0] APPLIED_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] routine_id;
        logic [2:0]  step_slot;
        logic [2:0]  zone_number;
        logic [10:0] step_minutes;
        logic [3:0]  step_total;
        logic [16:0] elapsed_seconds;
        logic        check_ok;
        logic        open_request;
    } vzs_item_t;

    typedef struct packed {
        logic        close_pulse;
        logic [1:0]  close_zone;
        logic        open_pulse;
        logic [1:0]  open_zone;
        logic [2:0]  status;
        logic [3:0]  step_number;
        logic [15:0] wake_seconds;
        logic        report_open;
    } vzs_result_t;

    // Write command to the step table. A write with set low clears the valid bit.
    typedef struct packed {
        logic        en;
        logic        set;
        logic [2:0]  slot;
        logic [1:0]  zone;
        logic [10:0] minutes;
    } vzs_slot_wr_t;

    // One step as read from the step table.
    typedef struct packed {
        logic [1:0]  zone;
        logic [10:0] minutes;
    } vzs_slot_rd_t;

endpackage

// ===== hdl/vzs_item_if.sv =====
// Input channel of the valve zone step sequencer: valid, ready and one item.
// Depends on vzs_pkg.
interface vzs_item_if
    import vzs_pkg::*;
();
    logic      valid;
    logic      ready;
    vzs_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/vzs_result_if.sv =====
// Result channel of the valve zone step sequencer: valid, ready and one result.
// Depends on vzs_pkg.
interface vzs_result_if
    import vzs_pkg::*;
();
    logic        valid;
    logic        ready;
    vzs_result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/valve_zone_step_sequencer.sv =====
// Valve zone step sequencer. One transaction is accepted every clock cycle
// while results are taken; each item waits in the input register, then the
// core's state update (countdown, step table read, step seconds and wake
// interval) ends in the result register, so the sustained rate is one item
// per cycle. There is no clearing pass after reset: the step table valid
// bits clear at once. Configuration registers are to be written through the
// plain write port only while no transaction is in flight; the block itself
// does not enforce this.
// Depends on vzs_pkg, vzs_item_if, vzs_result_if, vzs_slot_table and vzs_core.
module valve_zone_step_sequencer
    import vzs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    vzs_item_if.sink    item_in,
    vzs_result_if.source result_out
);

    logic                  item_valid_reg;
    vzs_item_t             item_reg;
    logic                  core_ready;
    vzs_slot_wr_t          slot_wr;
    logic [2:0]            slot_rd_addr;
    vzs_slot_rd_t          slot_rd;
    logic [SLOT_COUNT-1:0] slot_valid;

    // Input register: refills as soon as the core takes its transaction.
    assign item_in.ready = !item_valid_reg || core_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            item_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            item_reg <= item_in.payload;
        end
    end

    vzs_slot_table u_slot_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (slot_wr),
        .rd_addr    (slot_rd_addr),
        .rd         (slot_rd),
        .valid_mask (slot_valid)
    );

    vzs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid_reg),
        .item         (item_reg),
        .item_ready   (core_ready),
        .res_valid    (result_out.valid),
        .res          (result_out.payload),
        .res_ready    (result_out.ready),
        .slot_wr      (slot_wr),
        .slot_rd_addr (slot_rd_addr),
        .slot_rd      (slot_rd),
        .slot_valid   (slot_valid)
    );

endmodule

// ===== hdl/vzs_slot_table.sv =====
// Step table of the sequencer: zone and minutes per slot, plus a valid bit each.
// Depends on vzs_pkg.
module vzs_slot_table
    import vzs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vzs_slot_wr_t          wr,
    input  logic [2:0]            rd_addr,
    output vzs_slot_rd_t          rd,
    output logic [SLOT_COUNT-1:0] valid_mask
);

    logic [1:0]            slot_zone_reg [SLOT_COUNT];
    logic [10:0]           slot_minutes_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_valid_reg;

    // Step data holds no reset; a slot is read only after it was written.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.set)
        begin
            slot_zone_reg[wr.slot] <= wr.zone;
            slot_minutes_reg[wr.slot] <= wr.minutes;
        end
    end

    // Valid bits are set by a good load and cleared by a bad one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (wr.en)
        begin
            slot_valid_reg[wr.slot] <= wr.set;
        end
    end

    assign rd.zone = slot_zone_reg[rd_addr];
    assign rd.minutes = slot_minutes_reg[rd_addr];
    assign valid_mask = slot_valid_reg;

endmodule

// ===== hdl/vzs_core.sv =====
// Sequencer core: routine state, configuration registers, the per-item update
// and the result register. Depends on vzs_pkg; drives the step table.
module vzs_core
    import vzs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  item_valid,
    input  vzs_item_t             item,
    output logic                  item_ready,
    output logic                  res_valid,
    output vzs_result_t           res,
    input  logic                  res_ready,
    output vzs_slot_wr_t          slot_wr,
    output logic [2:0]            slot_rd_addr,
    input  vzs_slot_rd_t          slot_rd,
    input  logic [SLOT_COUNT-1:0] slot_valid
);

    // Configuration registers.
    logic [15:0] default_wake_reg;
    logic [15:0] poll_reg;

    // Routine state.
    logic        active_reg, active_next;
    logic [31:0] active_id_reg, active_id_next;
    logic [31:0] completed_id_reg, completed_id_next;
    logic [3:0]  steps_reg, steps_next;
    logic [2:0]  step_index_reg, step_index_next;
    logic        zone_open_reg, zone_open_next;
    logic [1:0]  current_zone_reg, current_zone_next;
    logic [16:0] remaining_reg, remaining_next;
    logic [1:0]  applied_reg [VALVE_ZONES];
    logic [1:0]  applied_next [VALVE_ZONES];

    // Result register.
    logic        res_valid_reg;
    vzs_result_t res_reg, res_next;

    logic                  fire;
    logic                  pending;
    logic [16:0]           remaining_sub;
    logic [3:0]            next_index;
    logic [16:0]           step_seconds;
    logic                  zone_ok;
    logic                  minutes_ok;
    logic [1:0]            zone_index;
    logic [SLOT_COUNT-1:0] need_mask;
    logic                  start_ok;
    logic [16:0]           wake_full;

    // One item per cycle whenever the result register is free or being emptied.
    assign item_ready = !res_valid_reg || res_ready;
    assign fire = item_valid && item_ready;

    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // Decoding of the item fields shared by several actions.
    assign zone_ok = (item.zone_number >= 3'd1) && (item.zone_number <= ZONES);
    assign minutes_ok = (item.step_minutes >= 11'd1) && (item.step_minutes <= MINUTES_LIMIT);
    assign zone_index = item.zone_number[1:0] - 2'd1;
    assign next_index = {1'b0, step_index_reg} + 4'd1;

    // A start opens slot 0; a tick opens the slot after the current one.
    assign slot_rd_addr = (item.action == ACT_START) ? 3'd0 : next_index[2:0];
    assign step_seconds = {6'd0, slot_rd.minutes} * SEC_PER_MIN;

    // Countdown of the open step, saturating at zero.
    assign remaining_sub = (item.elapsed_seconds >= remaining_reg) ? 17'd0
                         : remaining_reg - item.elapsed_seconds;

    // A start needs every slot below the step count to be valid.
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            need_mask[i] = (4'(i) < item.step_total);
        end
        start_ok = (item.step_total >= 4'd1) && (item.step_total <= MAX_STEPS)
                && ((slot_valid & need_mask) == need_mask);
    end

    // Next state and result of the item at the input.
    always_comb
    begin
        active_next = active_reg;
        active_id_next = active_id_reg;
        completed_id_next = completed_id_reg;
        steps_next = steps_reg;
        step_index_next = step_index_reg;
        zone_open_next = zone_open_reg;
        current_zone_next = current_zone_reg;
        remaining_next = remaining_reg;
        applied_next = applied_reg;
        res_next = '0;
        res_next.status = active_reg ? ST_WATERING : ST_IDLE;
        slot_wr = '0;
        pending = 1'b0;
        wake_full = '0;

        case (item.action)
            ACT_TICK:
            begin
                if (active_reg)
                begin
                    // An open zone always has time left, so no reload is needed here.
                    if (zone_open_reg)
                    begin
                        remaining_next = remaining_sub;
                        if (remaining_sub == 17'd0)
                        begin
                            res_next.close_pulse = 1'b1;
                            res_next.close_zone = current_zone_reg;
                            applied_next[current_zone_reg] = APPLIED_CLOSED;
                            zone_open_next = 1'b0;
                            pending = 1'b1;
                        end
                    end
                    else
                    begin
                        pending = 1'b1;
                    end
                    // Advance only once the remote check succeeded.
                    if (pending && item.check_ok)
                    begin
                        if (next_index >= steps_reg)
                        begin
                            completed_id_next = active_id_reg;
                            active_next = 1'b0;
                            zone_open_next = 1'b0;
                            remaining_next = '0;
                            res_next.status = ST_FINISHED;
                        end
                        else
                        begin
                            step_index_next = next_index[2:0];
                            res_next.open_pulse = 1'b1;
                            res_next.open_zone = slot_rd.zone;
                            applied_next[slot_rd.zone] = APPLIED_OPEN;
                            zone_open_next = 1'b1;
                            current_zone_next = slot_rd.zone;
                            remaining_next = step_seconds;
                            res_next.status = ST_WATERING;
                        end
                    end
                end
            end
            ACT_LOAD:
            begin
                if ({1'b0, item.step_slot} >= MAX_STEPS)
                begin
                    res_next.status = ST_REJECTED;
                end
                else
                begin
                    // The table is written only by an accepted transaction.
                    slot_wr.en = fire;
                    slot_wr.slot = item.step_slot;
                    slot_wr.zone = zone_index;
                    slot_wr.minutes = item.step_minutes;
                    slot_wr.set = zone_ok && minutes_ok;
                    if (!(zone_ok && minutes_ok))
                    begin
                        res_next.status = ST_REJECTED;
                    end
                end
            end
            ACT_START:
            begin
                if (item.routine_id == 32'd0)
                begin
                    res_next.status = ST_REJECTED;
                end
                else if (active_reg && (active_id_reg == item.routine_id))
                begin
                    res_next.status = ST_WATERING;
                end
                else if (!active_reg && (completed_id_reg == item.routine_id))
                begin
                    res_next.status = ST_FINISHED;
                end
                else if (!start_ok)
                begin
                    res_next.status = ST_REJECTED;
                end
                else
                begin
                    // Close the zone of a running routine, then open step 0.
                    if (zone_open_reg)
                    begin
                        res_next.close_pulse = 1'b1;
                        res_next.close_zone = current_zone_reg;
                        applied_next[current_zone_reg] = APPLIED_CLOSED;
                    end
                    active_next = 1'b1;
                    active_id_next = item.routine_id;
                    completed_id_next = '0;
                    steps_next = item.step_total;
                    step_index_next = 3'd0;
                    res_next.open_pulse = 1'b1;
                    res_next.open_zone = slot_rd.zone;
                    applied_next[slot_rd.zone] = APPLIED_OPEN;
                    zone_open_next = 1'b1;
                    current_zone_next = slot_rd.zone;
                    remaining_next = step_seconds;
                    res_next.status = ST_WATERING;
                end
            end
            ACT_STOP:
            begin
                if (zone_open_reg)
                begin
                    res_next.close_pulse = 1'b1;
                    res_next.close_zone = current_zone_reg;
                    applied_next[current_zone_reg] = APPLIED_CLOSED;
                end
                zone_open_next = 1'b0;
                active_next = 1'b0;
                remaining_next = '0;
                steps_next = '0;
                step_index_next = '0;
                completed_id_next = '0;
                res_next.status = ST_DISABLED;
            end
            ACT_MANUAL:
            begin
                if (!zone_ok)
                begin
                    res_next.status = ST_REJECTED;
                end
                else if (active_reg)
                begin
                    res_next.status = ST_REFUSED;
                    res_next.report_open = (applied_reg[zone_index] == APPLIED_OPEN);
                end
                else
                begin
                    // Pulse only when the valve is not already in the requested state.
                    if (applied_reg[zone_index] != {1'b0, item.open_request})
                    begin
                        if (item.open_request)
                        begin
                            res_next.open_pulse = 1'b1;
                            res_next.open_zone = zone_index;
                        end
                        else
                        begin
                            res_next.close_pulse = 1'b1;
                            res_next.close_zone = zone_index;
                        end
                        applied_next[zone_index] = {1'b0, item.open_request};
                    end
                    res_next.report_open = item.open_request;
                    res_next.status = ST_IDLE;
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase

        // Step number and wake interval follow the state after the item.
        res_next.step_number = active_next ? ({1'b0, step_index_next} + 4'd1) : 4'd0;
        if (!active_next)
        begin
            wake_full = {1'b0, default_wake_reg};
        end
        else if (!zone_open_next)
        begin
            wake_full = {1'b0, poll_reg};
        end
        else if (remaining_next == 17'd0)
        begin
            wake_full = 17'd1;
        end
        else if (remaining_next > {1'b0, poll_reg})
        begin
            wake_full = {1'b0, poll_reg};
        end
        else
        begin
            wake_full = remaining_next;
        end
        res_next.wake_seconds = (wake_full == 17'd0) ? 16'd1 : wake_full[15:0];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_wake_reg <= DEFAULT_WAKE_RESET;
            poll_reg <= POLL_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_DEFAULT_WAKE)
            begin
                default_wake_reg <= cfg_data;
            end
            else
            begin
                poll_reg <= cfg_data;
            end
        end
    end

    // Routine state moves on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            active_id_reg <= '0;
            completed_id_reg <= '0;
            steps_reg <= '0;
            step_index_reg <= '0;
            zone_open_reg <= 1'b0;
            current_zone_reg <= '0;
            remaining_reg <= '0;
            for (int i = 0; i < VALVE_ZONES; i++)
            begin
                applied_reg[i] <= APPLIED_UNKNOWN;
            end
        end
        else if (fire)
        begin
            active_reg <= active_next;
            active_id_reg <= active_id_next;
            completed_id_reg <= completed_id_next;
            steps_reg <= steps_next;
            step_index_reg <= step_index_next;
            zone_open_reg <= zone_open_next;
            current_zone_reg <= current_zone_next;
            remaining_reg <= remaining_next;
            applied_reg <= applied_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/vzs_checker.sv =====
// Port-level checks of the valve zone step sequencer result channel, and the
// bind that attaches them to the top level. Depends on vzs_pkg.
module vzs_checker
    import vzs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input vzs_result_t out_data
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The wake interval is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.wake_seconds != 16'd0)
        else $error("zero wake interval");

    // Idle, finished and disabled all leave no routine running.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_IDLE || out_data.status == ST_FINISHED
                      || out_data.status == ST_DISABLED)
        |-> out_data.step_number == 4'd0)
        else $error("step number shown without a running routine");

    // A routine open pulse always comes with a running step.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.open_pulse && out_data.status != ST_IDLE
        |-> out_data.step_number != 4'd0)
        else $error("routine opened a zone without a step");

endmodule

bind valve_zone_step_sequencer vzs_checker u_vzs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_data  (result_out.payload)
);

// ===== sim/vzs_sequencer_checker.sv =====
// Checker of the valve zone step sequencer: it watches the item, result and register-write
// ports, predicts each result and compares it field by field with what the block returns.
// Depends on vzs_pkg, vzs_item_if and vzs_result_if.
`timescale 1ns / 100ps

module vzs_sequencer_checker
    import vzs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    vzs_item_if         item_ch,
    vzs_result_if       result_ch,
    output int          fail_count,
    output int          pending_count
);

    // Predicted copy of the sequencer state and its two registers.
    logic        run_active;
    logic [31:0] run_id;
    logic [31:0] done_id;
    logic [3:0]  run_steps;
    logic [2:0]  run_index;
    logic        valve_open;
    logic [1:0]  valve_zone;
    logic [16:0] secs_left;
    logic [1:0]  tbl_zone [SLOT_COUNT];
    logic [10:0] tbl_minutes [SLOT_COUNT];
    logic        tbl_valid [SLOT_COUNT];
    logic [1:0]  valve_state [VALVE_ZONES];
    logic [15:0] wake_default;
    logic [15:0] wake_poll;

    // Result under construction, and results still owed by the block.
    vzs_result_t outcome;
    vzs_result_t oldest;
    vzs_result_t pending_results [$];

    function automatic logic [16:0] step_seconds(input logic [2:0] slot);
        return 17'(tbl_minutes[slot]) * SEC_PER_MIN;
    endfunction

    // Closes the open valve, if any, and records the close pulse.
    function automatic void close_valve();
        if (valve_open)
        begin
            outcome.close_pulse = 1'b1;
            outcome.close_zone = valve_zone;
            valve_state[valve_zone] = APPLIED_CLOSED;
        end
        valve_open = 1'b0;
    endfunction

    // Opens the zone of the given step and loads its full duration.
    function automatic void open_step(input logic [2:0] slot);
        logic [1:0] zone;
        zone = tbl_zone[slot];
        run_index = slot;
        outcome.open_pulse = 1'b1;
        outcome.open_zone = zone;
        valve_state[zone] = APPLIED_OPEN;
        valve_open = 1'b1;
        valve_zone = zone;
        secs_left = step_seconds(slot);
        outcome.status = ST_WATERING;
    endfunction

    // Applies one input transaction to the predicted state and returns its result.
    function automatic vzs_result_t sequence_item(input vzs_item_t it);
        logic        step_done;
        logic        start_ok;
        logic [3:0]  next_index;
        logic [1:0]  zi;
        logic [1:0]  wanted;
        logic [16:0] wake_span;
        int          s;
        outcome = '0;
        outcome.status = run_active ? ST_WATERING : ST_IDLE;
        case (it.action)
            ACT_TICK:
            begin
                if (run_active)
                begin
                    step_done = 1'b0;
                    if (valve_open)
                    begin
                        // A zone opened with no time left gets its step duration back first.
                        if (secs_left == 17'd0 && {1'b0, run_index} < run_steps)
                            secs_left = step_seconds(run_index);
                        secs_left = (it.elapsed_seconds >= secs_left) ? 17'd0
                                                                      : secs_left - it.elapsed_seconds;
                        if (secs_left == 17'd0)
                        begin
                            close_valve();
                            step_done = 1'b1;
                        end
                    end
                    else
                    begin
                        step_done = 1'b1;
                    end
                    // Advancing waits for a tick whose remote check succeeded.
                    if (step_done && it.check_ok)
                    begin
                        next_index = {1'b0, run_index} + 4'd1;
                        if (next_index >= run_steps)
                        begin
                            done_id = run_id;
                            run_active = 1'b0;
                            valve_open = 1'b0;
                            secs_left = 17'd0;
                            outcome.status = ST_FINISHED;
                        end
                        else
                        begin
                            open_step(next_index[2:0]);
                        end
                    end
                end
            end
            ACT_LOAD:
            begin
                // The slot field is three bits wide, so every slot is inside the table.
                if (it.zone_number < 3'd1 || it.zone_number > ZONES ||
                    it.step_minutes < 11'd1 || it.step_minutes > MINUTES_LIMIT)
                begin
                    tbl_valid[it.step_slot] = 1'b0;
                    outcome.status = ST_REJECTED;
                end
                else
                begin
                    tbl_zone[it.step_slot] = 2'(it.zone_number - 3'd1);
                    tbl_minutes[it.step_slot] = it.step_minutes;
                    tbl_valid[it.step_slot] = 1'b1;
                end
            end
            ACT_START:
            begin
                if (it.routine_id == 32'd0)
                begin
                    outcome.status = ST_REJECTED;
                end
                else if (run_active && run_id == it.routine_id)
                begin
                    outcome.status = ST_WATERING;
                end
                else if (!run_active && done_id == it.routine_id)
                begin
                    outcome.status = ST_FINISHED;
                end
                else
                begin
                    start_ok = (it.step_total >= 4'd1 && it.step_total <= MAX_STEPS);
                    for (s = 0; s < SLOT_COUNT; s++)
                        if (s < int'(it.step_total) && !tbl_valid[s])
                            start_ok = 1'b0;
                    if (!start_ok)
                    begin
                        outcome.status = ST_REJECTED;
                    end
                    else
                    begin
                        close_valve();
                        run_active = 1'b1;
                        run_id = it.routine_id;
                        done_id = 32'd0;
                        run_steps = it.step_total;
                        open_step(3'd0);
                    end
                end
            end
            ACT_STOP:
            begin
                close_valve();
                run_active = 1'b0;
                secs_left = 17'd0;
                run_steps = 4'd0;
                run_index = 3'd0;
                done_id = 32'd0;
                outcome.status = ST_DISABLED;
            end
            ACT_MANUAL:
            begin
                if (it.zone_number < 3'd1 || it.zone_number > ZONES)
                begin
                    outcome.status = ST_REJECTED;
                end
                else
                begin
                    zi = 2'(it.zone_number - 3'd1);
                    if (run_active)
                    begin
                        outcome.status = ST_REFUSED;
                        outcome.report_open = (valve_state[zi] == APPLIED_OPEN);
                    end
                    else
                    begin
                        // A pulse goes out only when the valve is not already in that state.
                        wanted = it.open_request ? APPLIED_OPEN : APPLIED_CLOSED;
                        if (valve_state[zi] != wanted)
                        begin
                            if (it.open_request)
                            begin
                                outcome.open_pulse = 1'b1;
                                outcome.open_zone = zi;
                            end
                            else
                            begin
                                outcome.close_pulse = 1'b1;
                                outcome.close_zone = zi;
                            end
                            valve_state[zi] = wanted;
                        end
                        outcome.report_open = it.open_request;
                        outcome.status = ST_IDLE;
                    end
                end
            end
            default:
            begin
                // Unused action codes leave everything as it is.
            end
        endcase

        outcome.step_number = run_active ? {1'b0, run_index} + 4'd1 : 4'd0;

        // Wake interval: default when idle, poll while waiting, else the countdown capped.
        if (!run_active)
            wake_span = {1'b0, wake_default};
        else if (!valve_open)
            wake_span = {1'b0, wake_poll};
        else if (secs_left == 17'd0)
            wake_span = 17'd1;
        else
            wake_span = (secs_left > {1'b0, wake_poll}) ? {1'b0, wake_poll} : secs_left;
        outcome.wake_seconds = (wake_span == 17'd0) ? 16'd1 : wake_span[15:0];
        return outcome;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endfunction

    // Compare accepted results, predict accepted items and follow register writes.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active = 1'b0;
            run_id = 32'd0;
            done_id = 32'd0;
            run_steps = 4'd0;
            run_index = 3'd0;
            valve_open = 1'b0;
            valve_zone = 2'd0;
            secs_left = 17'd0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                tbl_zone[s] = 2'd0;
                tbl_minutes[s] = 11'd0;
                tbl_valid[s] = 1'b0;
            end
            for (int z = 0; z < VALVE_ZONES; z++)
                valve_state[z] = APPLIED_UNKNOWN;
            wake_default = DEFAULT_WAKE_RESET;
            wake_poll = POLL_RESET;
            pending_results.delete();
            fail_count = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction arrived with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    check_field("close_pulse", oldest.close_pulse, result_ch.payload.close_pulse);
                    check_field("close_zone", oldest.close_zone, result_ch.payload.close_zone);
                    check_field("open_pulse", oldest.open_pulse, result_ch.payload.open_pulse);
                    check_field("open_zone", oldest.open_zone, result_ch.payload.open_zone);
                    check_field("status", oldest.status, result_ch.payload.status);
                    check_field("step_number", oldest.step_number, result_ch.payload.step_number);
                    check_field("wake_seconds", oldest.wake_seconds,
                                result_ch.payload.wake_seconds);
                    check_field("report_open", oldest.report_open, result_ch.payload.report_open);
                end
            end
            if (item_ch.valid && item_ch.ready)
                pending_results.push_back(sequence_item(item_ch.payload));
            if (cfg_write)
            begin
                if (cfg_index == CFG_DEFAULT_WAKE)
                    wake_default = cfg_data;
                else
                    wake_poll = cfg_data;
            end
        end
        pending_count <= pending_results.size();
    end

endmodule

// ===== sim/tb_valve_zone_step_sequencer.sv =====
// Top of the valve zone step sequencer testbench: clock, reset, register writes, item stimulus
// with random gaps, result back-pressure, watchdog and the final verdict.
// Depends on vzs_pkg, vzs_item_if, vzs_result_if, valve_zone_step_sequencer, vzs_sequencer_checker.
`timescale 1ns / 100ps

module tb_valve_zone_step_sequencer;
    import vzs_pkg::*;

    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 12;
    localparam int ITEM_TARGET = 900;
    localparam int PHASE_COUNT = 5;
    localparam int LONG_HOLD = 100;
    localparam int BURST_ITEMS = 30;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT = 1000;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending_count;
    int          items_sent = 0;
    int          hold_requests = 0;
    int          holds_started = 0;
    int          idle_cycles = 0;
    bit          gapless = 1'b0;
    logic [31:0] last_id = 32'd1;

    vzs_item_if   item_ch ();
    vzs_result_if result_ch ();

    valve_zone_step_sequencer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_in    (item_ch),
        .result_out (result_ch)
    );

    vzs_sequencer_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_ch       (item_ch),
        .result_ch     (result_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    // Watchdog: ends the run when no transaction moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one and rarely a long one.
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, runs of steady acceptance, and a long hold-off on request.
    initial
    begin
        int stretch;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_started != hold_requests)
            begin
                holds_started++;
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stretch = idle_length();
            if (stretch > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            stretch = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6);
            repeat (stretch) @(posedge clk);
        end
    end

    // Offers one transaction, after an optional gap, and returns once it is accepted.
    task automatic send_item(input vzs_item_t it);
        int gap;
        gap = gapless ? 0 : idle_length();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.payload <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] wake, input logic [15:0] poll);
        cfg_write <= 1'b1;
        cfg_index <= CFG_DEFAULT_WAKE;
        cfg_data <= wake;
        @(posedge clk);
        cfg_index <= CFG_POLL;
        cfg_data <= poll;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Every field random, so the fields an action ignores still toggle.
    function automatic vzs_item_t random_fields(input logic [2:0] act);
        vzs_item_t it;
        it.action = act;
        it.routine_id = $urandom;
        it.step_slot = 3'($urandom);
        it.zone_number = 3'($urandom);
        it.step_minutes = 11'($urandom);
        it.step_total = 4'($urandom);
        it.elapsed_seconds = 17'($urandom);
        it.check_ok = 1'($urandom);
        it.open_request = 1'($urandom);
        return it;
    endfunction

    function automatic vzs_item_t load_item(input int slot, input int zone, input int minutes);
        vzs_item_t it;
        it = random_fields(ACT_LOAD);
        it.step_slot = 3'(slot);
        it.zone_number = 3'(zone);
        it.step_minutes = 11'(minutes);
        return it;
    endfunction

    function automatic vzs_item_t start_item(input logic [31:0] id, input int total);
        vzs_item_t it;
        it = random_fields(ACT_START);
        it.routine_id = id;
        it.step_total = 4'(total);
        return it;
    endfunction

    function automatic vzs_item_t tick_item(input int elapsed, input bit check);
        vzs_item_t it;
        it = random_fields(ACT_TICK);
        it.elapsed_seconds = 17'(elapsed);
        it.check_ok = check;
        return it;
    endfunction

    function automatic vzs_item_t manual_item(input int zone, input bit open_req);
        vzs_item_t it;
        it = random_fields(ACT_MANUAL);
        it.zone_number = 3'(zone);
        it.open_request = open_req;
        return it;
    endfunction

    // Short steps keep routines moving; a few take the longest step or any length.
    function automatic int step_length();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return 1440;
        if (roll == 1)
            return $urandom_range(1, 1440);
        return $urandom_range(1, 3);
    endfunction

    function automatic int tick_seconds();
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 1;
        if (roll < 4)
            return $urandom_range(0, 131071);
        return $urandom_range(30, 240);
    endfunction

    // One routine: load its steps, start it, then mostly ticks with some interference.
    task automatic run_routine();
        int          steps;
        int          ticks;
        int          s;
        logic [31:0] id;
        steps = ($urandom_range(0, 4) == 0) ? MAX_STEPS : $urandom_range(1, 4);
        gapless = ($urandom_range(0, 3) == 0);
        for (s = 0; s < steps; s++)
            send_item(load_item(s, $urandom_range(1, VALVE_ZONES), step_length()));
        if ($urandom_range(0, 7) == 0)
            send_item(load_item($urandom_range(0, steps - 1), $urandom_range(0, 7),
                                $urandom_range(0, 2047)));
        id = ($urandom_range(0, 3) == 0) ? last_id : $urandom;
        last_id = id;
        send_item(start_item(id, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : steps));
        ticks = 3 * steps + $urandom_range(0, 4);
        for (s = 0; s < ticks; s++)
        begin
            case ($urandom_range(0, 19))
                0: send_item(random_fields(3'($urandom)));
                1: send_item(manual_item($urandom_range(0, 7), 1'($urandom)));
                2: send_item(load_item($urandom_range(0, steps - 1), $urandom_range(1, VALVE_ZONES),
                                       step_length()));
                3: send_item(start_item(($urandom_range(0, 1) == 0) ? id : $urandom, steps));
                default: send_item(tick_item(tick_seconds(), $urandom_range(0, 3) != 0));
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            send_item(random_fields(ACT_STOP));
        gapless = 1'b0;
    endtask

    // Stimulus: reset, a directed walk through the special cases, then random phases.
    initial
    begin
        int phase;
        int phase_goal;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_DEFAULT_WAKE;
        cfg_data <= 16'd0;
        item_ch.valid <= 1'b0;
        item_ch.payload <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        configure(16'd900, 16'd45);

        // Idle behavior, unused actions and manual commands.
        send_item(tick_item(131071, 1'b1));
        send_item(random_fields(3'd5));
        send_item(manual_item(0, 1'b1));
        send_item(manual_item(7, 1'b1));
        send_item(manual_item(1, 1'b1));
        send_item(manual_item(1, 1'b1));
        send_item(manual_item(VALVE_ZONES, 1'b0));
        // Bad and good loads of the step table.
        send_item(load_item(0, 0, 5));
        send_item(load_item(1, 2, 0));
        send_item(load_item(1, 2, 1441));
        send_item(load_item(2, 3, 2047));
        send_item(load_item(0, 1, 1));
        send_item(load_item(1, VALVE_ZONES, 1440));
        // Bad starts: zero id, counts out of range, an invalid slot within the count.
        send_item(start_item(32'd0, 2));
        send_item(start_item(32'd5, 0));
        send_item(start_item(32'd5, 9));
        send_item(start_item(32'd5, 3));
        // A full routine: repeated start, refused manual, failed check, finish, completed id.
        send_item(start_item(32'hFFFF_FFFF, 2));
        send_item(start_item(32'hFFFF_FFFF, 2));
        send_item(manual_item(1, 1'b0));
        send_item(tick_item(60, 1'b0));
        send_item(tick_item(0, 1'b1));
        send_item(tick_item(131071, 1'b1));
        send_item(start_item(32'hFFFF_FFFF, 2));
        send_item(random_fields(ACT_STOP));
        // Load during a routine, a new start over an open zone, and a stop while watering.
        send_item(start_item(32'd7, 2));
        send_item(load_item(1, 2, 2));
        send_item(start_item(32'd8, 1));
        send_item(random_fields(ACT_STOP));
        drain();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: configure(16'd1, 16'd1);
                1: configure(16'hFFFF, 16'hFFFF);
                2: configure(16'hFFFF, 16'd1);
                3: configure(16'd1, 16'hFFFF);
                default: configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 120)));
            endcase
            phase_goal = items_sent + ITEM_TARGET / PHASE_COUNT;
            if (phase == 1)
            begin
                // Hold the result side off while items keep coming, so the block backs up.
                hold_requests++;
                while (holds_started != hold_requests)
                    @(posedge clk);
                gapless = 1'b1;
                repeat (BURST_ITEMS) send_item(tick_item(tick_seconds(), 1'($urandom)));
                gapless = 1'b0;
            end
            while (items_sent < phase_goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 6)) send_item(random_fields(3'($urandom)));
                else
                    run_routine();
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
